FILE: hw/rtl/http_request_head_parser_macros.svh
// Assertion macros of the request head parser RTL.
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRHP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HRHP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hrhp_pkg.sv
// Types, codes and constants of the request head parser.
`default_nettype none

package hrhp_pkg;

  localparam int unsigned LEN_CNT_BITS   = 13;
  localparam int unsigned PATH_LIM_BITS  = 13;
  localparam int unsigned FIELD_LIM_BITS = 8;
  localparam int unsigned METHOD_MAX_LEN = 7;

  typedef logic [LEN_CNT_BITS-1:0]   len_cnt_t;
  typedef logic [PATH_LIM_BITS-1:0]  path_lim_t;
  typedef logic [FIELD_LIM_BITS-1:0] field_lim_t;

  typedef enum logic [21:0] {
    PH_LEADING    = 22'h000001,
    PH_METHOD     = 22'h000002,
    PH_SLASH      = 22'h000004,
    PH_PATH       = 22'h000008,
    PH_V_H        = 22'h000010,
    PH_V_T1       = 22'h000020,
    PH_V_T2       = 22'h000040,
    PH_V_P        = 22'h000080,
    PH_V_SLASH    = 22'h000100,
    PH_V_MAJOR    = 22'h000200,
    PH_V_DOT      = 22'h000400,
    PH_V_MINOR    = 22'h000800,
    PH_RL_CR      = 22'h001000,
    PH_RL_LF      = 22'h002000,
    PH_LINE_START = 22'h004000,
    PH_NAME       = 22'h008000,
    PH_VALUE_WS   = 22'h010000,
    PH_VALUE      = 22'h020000,
    PH_FIELD_LF   = 22'h040000,
    PH_END_LF     = 22'h080000,
    PH_DONE       = 22'h100000,
    PH_ERROR      = 22'h200000
  } phase_t;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_PATH     = 3'd1,
    EV_NAME     = 3'd2,
    EV_VALUE    = 3'd3,
    EV_LINE     = 3'd4,
    EV_FIELD    = 3'd5,
    EV_HEAD     = 3'd6,
    EV_ERROR    = 3'd7
  } ev_code_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_METHOD  = 3'd1,
    ERR_SPACE   = 3'd2,
    ERR_PATH    = 3'd3,
    ERR_VERSION = 3'd4,
    ERR_CRLF    = 3'd5,
    ERR_NAME    = 3'd6,
    ERR_VALUE   = 3'd7
  } err_code_t;

  typedef enum logic [1:0] {
    METH_GET  = 2'd0,
    METH_HEAD = 2'd1,
    METH_POST = 2'd2
  } meth_code_t;

  typedef enum logic [1:0] {
    CFG_PATH_LEN  = 2'd0,
    CFG_NAME_LEN  = 2'd1,
    CFG_VALUE_LEN = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] meth_match;
    len_cnt_t   field_len;
    meth_code_t meth;
    logic [3:0] major;
    logic [3:0] minor;
    err_code_t  err;
  } parse_state_t;

  typedef struct packed {
    path_lim_t  path_lim;
    field_lim_t name_lim;
    field_lim_t value_lim;
  } limits_t;

  typedef struct packed {
    ev_code_t   ev;
    logic [7:0] data;
  } step_res_t;

  localparam parse_state_t ST_RESET = '{
    phase:      PH_LEADING,
    meth_match: 3'b111,
    field_len:  '0,
    meth:       METH_GET,
    major:      4'd0,
    minor:      4'd0,
    err:        ERR_NONE
  };

  localparam limits_t LIM_RESET = '{
    path_lim:  path_lim_t'(8000),
    name_lim:  field_lim_t'(200),
    value_lim: field_lim_t'(200)
  };

endpackage

`default_nettype wire

FILE: hw/rtl/http_request_head_parser.sv
// HTTP/1.1 request head parser: one byte in, one event out per word.
//
// Input channel (in_valid / in_stall) carries one byte of the request stream
// per word, with in_begin_request set on the first byte of a new request.
// Output channel (out_valid / out_stall) returns exactly one word per input
// word: an event code, the path / lowercased name / value byte where the
// event carries one, and the held method, version digits and error kind.
// Configuration channel (cfg_valid / cfg_ready, always ready) writes the
// path, header name and header value length limits by index; write only
// while the parser is idle.
// Path: each byte passes through the input register, then the result
// register. Throughput: one byte per cycle while the receiver does not
// stall, set by the single state update between the two registers.
// Reset: parser awaits a request line, limits return to 8000 / 200 / 200,
// both registers empty. No clearing pass is needed.
// Receiver stall: the result register holds its word; the input register
// fills behind it and in_stall rises only when both are occupied.
// Errors are sticky: every byte answers the error event until
// in_begin_request starts a new request.
`default_nettype none

module http_request_head_parser (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_begin_request,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_method_code,
  output logic [3:0] out_version_major,
  output logic [3:0] out_version_minor,
  output logic [2:0] out_error_kind,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import hrhp_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_begin_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  limits_t      lim_r;
  step_res_t    step_res;
  logic         out_valid_r;
  step_res_t    out_res_r;
  parse_state_t out_st_r;
  logic         out_load;
  logic         advance;
  logic         in_take;

  assign out_load  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  hrhp_step u_step (
    .st            (st_r),
    .lim           (lim_r),
    .data_byte     (s1_byte_r),
    .begin_request (s1_begin_r),
    .st_nxt        (st_nxt),
    .res           (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_begin_r <= in_begin_request;
    end
  end

  // Parser state advances with each word moved into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATH_LEN:  lim_r.path_lim  <= cfg_data[PATH_LIM_BITS-1:0];
        CFG_NAME_LEN:  lim_r.name_lim  <= cfg_data[FIELD_LIM_BITS-1:0];
        CFG_VALUE_LEN: lim_r.value_lim <= cfg_data[FIELD_LIM_BITS-1:0];
        default: begin
          lim_r <= lim_r;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
      out_st_r  <= st_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_res_r.ev;
  assign out_out_byte      = out_res_r.data;
  assign out_method_code   = out_st_r.meth;
  assign out_version_major = out_st_r.major;
  assign out_version_minor = out_st_r.minor;
  assign out_error_kind    = out_st_r.err;

`include "http_request_head_parser_macros.svh"

  `HRHP_CHECK(a_err_event_kind, out_valid_r, ((out_event_res == EV_ERROR) == (out_error_kind != ERR_NONE)), "error event and held error kind disagree")
  `HRHP_CHECK(a_name_lower, out_valid_r && out_event_res == EV_NAME, !(out_out_byte >= 8'h41 && out_out_byte <= 8'h5A), "header name byte not lowercased")
  `HRHP_CHECK(a_byte_zero, out_valid_r && out_event_res != EV_PATH && out_event_res != EV_NAME && out_event_res != EV_VALUE, out_out_byte == 8'h00, "data byte set on non-data event")
  `HRHP_CHECK(a_held_range, out_valid_r, out_version_major <= 4'd9 && out_version_minor <= 4'd9 && out_method_code != 2'd3, "held method or version out of range")
  `HRHP_CHECK_NEXT(a_fill_result, s1_valid_r && !out_valid_r, out_valid_r, "pending word not moved into empty result register")

endmodule

`default_nettype wire

FILE: hw/rtl/hrhp_step.sv
// Per-word parse step: next parser state and result from the current word.
`default_nettype none

module hrhp_step (
  input  hrhp_pkg::parse_state_t st,
  input  hrhp_pkg::limits_t      lim,
  input  logic [7:0]             data_byte,
  input  logic                   begin_request,
  output hrhp_pkg::parse_state_t st_nxt,
  output hrhp_pkg::step_res_t    res
);
  import hrhp_pkg::*;

  localparam int unsigned CMP_W =
    (LEN_CNT_BITS > PATH_LIM_BITS) ? LEN_CNT_BITS : PATH_LIM_BITS;
  localparam len_cnt_t CNT_ALL_ONES = '1;

  function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          2'd0: c = "G";
          2'd1: c = "E";
          2'd2: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          2'd0: c = "H";
          2'd1: c = "E";
          2'd2: c = "A";
          default: c = "D";
        endcase
      end
      default: begin
        case (pos)
          2'd0: c = "P";
          2'd1: c = "O";
          2'd2: c = "S";
          default: c = "T";
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] meth_len(input logic [1:0] k);
    return (k == 2'd0) ? 3'd3 : 3'd4;
  endfunction

  parse_state_t     cur;
  logic             is_ws;
  logic             is_digit;
  logic [2:0]       mm_step;
  logic [2:0]       len_sel;
  len_cnt_t         len_base;
  len_cnt_t         len_inc;
  logic [CMP_W-1:0] lim_ext;
  logic             len_over;
  logic [7:0]       lower;

  assign cur      = begin_request ? ST_RESET : st;
  assign is_ws    = (data_byte == CH_SPACE) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
  assign is_digit = (data_byte >= "0") && (data_byte <= "9");
  assign lower    = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;

  // Narrow candidates by the byte at the current method position.
  always_comb begin
    logic [2:0] pos;
    pos = (cur.phase == PH_LEADING) ? 3'd0 : cur.field_len[2:0];
    for (int k = 0; k < 3; k++) begin
      mm_step[k] = ((cur.phase == PH_LEADING) ? 1'b1 : cur.meth_match[k]) &&
                   (pos < meth_len(2'(k))) &&
                   (meth_char(2'(k), pos[1:0]) == data_byte);
    end
  end

  // Length counter: header fields restart from zero on their first byte.
  always_comb begin
    len_sel  = 3'b001;
    len_base = cur.field_len;
    if (cur.phase == PH_LINE_START || cur.phase == PH_VALUE_WS) begin
      len_base = '0;
    end
    if (cur.phase == PH_LINE_START || cur.phase == PH_NAME) begin
      len_sel = 3'b010;
    end else if (cur.phase == PH_VALUE_WS || cur.phase == PH_VALUE) begin
      len_sel = 3'b100;
    end
    case (len_sel)
      3'b010:  lim_ext = CMP_W'(lim.name_lim);
      3'b100:  lim_ext = CMP_W'(lim.value_lim);
      default: lim_ext = CMP_W'(lim.path_lim);
    endcase
  end

  assign len_over = CMP_W'(len_base) >= lim_ext;
  assign len_inc  = (len_base != CNT_ALL_ONES) ? len_base + len_cnt_t'(1) : len_base;

  always_comb begin
    st_nxt   = cur;
    res.ev   = EV_CONSUMED;
    res.data = 8'h00;
    unique case (cur.phase)
      PH_LEADING: begin
        if (!is_ws) begin
          st_nxt.meth_match = mm_step;
          st_nxt.field_len  = len_cnt_t'(1);
          st_nxt.phase      = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (data_byte == CH_SPACE) begin
          st_nxt.err   = ERR_METHOD;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
          for (int k = 0; k < 3; k++) begin
            if (cur.meth_match[k] && cur.field_len == len_cnt_t'(meth_len(2'(k)))) begin
              st_nxt.meth  = meth_code_t'(k);
              st_nxt.err   = ERR_NONE;
              st_nxt.phase = PH_SLASH;
              res.ev       = EV_CONSUMED;
            end
          end
        end else if (cur.field_len >= len_cnt_t'(METHOD_MAX_LEN)) begin
          st_nxt.err   = ERR_METHOD;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end else begin
          st_nxt.meth_match = mm_step;
          st_nxt.field_len  = cur.field_len + len_cnt_t'(1);
        end
      end
      PH_SLASH: begin
        st_nxt.field_len = '0;
        if (data_byte == CH_SLASH) begin
          st_nxt.phase = PH_PATH;
        end else begin
          st_nxt.err   = ERR_PATH;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end
      end
      PH_PATH: begin
        if (data_byte == CH_SPACE) begin
          st_nxt.phase = PH_V_H;
        end else if (len_over) begin
          st_nxt.err   = ERR_PATH;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end else begin
          st_nxt.field_len = len_inc;
          res.ev           = EV_PATH;
          res.data         = data_byte;
        end
      end
      PH_V_H, PH_V_T1, PH_V_T2, PH_V_P, PH_V_SLASH, PH_V_DOT: begin
        logic [7:0] want;
        phase_t     nph;
        want = CH_DOT;
        nph  = PH_V_MINOR;
        if (cur.phase == PH_V_H) begin
          want = "H";
          nph  = PH_V_T1;
        end else if (cur.phase == PH_V_T1) begin
          want = "T";
          nph  = PH_V_T2;
        end else if (cur.phase == PH_V_T2) begin
          want = "T";
          nph  = PH_V_P;
        end else if (cur.phase == PH_V_P) begin
          want = "P";
          nph  = PH_V_SLASH;
        end else if (cur.phase == PH_V_SLASH) begin
          want = CH_SLASH;
          nph  = PH_V_MAJOR;
        end
        if (data_byte == want) begin
          st_nxt.phase = nph;
        end else begin
          st_nxt.err   = ERR_VERSION;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end
      end
      PH_V_MAJOR, PH_V_MINOR: begin
        if (!is_digit) begin
          st_nxt.err   = ERR_VERSION;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end else if (cur.phase == PH_V_MAJOR) begin
          st_nxt.major = data_byte[3:0];
          st_nxt.phase = PH_V_DOT;
        end else begin
          st_nxt.minor = data_byte[3:0];
          st_nxt.phase = PH_RL_CR;
        end
      end
      PH_RL_CR: begin
        if (data_byte == CH_CR) begin
          st_nxt.phase = PH_RL_LF;
        end else begin
          st_nxt.err   = ERR_CRLF;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end
      end
      PH_RL_LF, PH_FIELD_LF, PH_END_LF: begin
        if (data_byte == CH_LF) begin
          if (cur.phase == PH_RL_LF) begin
            st_nxt.phase = PH_LINE_START;
            res.ev       = EV_LINE;
          end else if (cur.phase == PH_FIELD_LF) begin
            st_nxt.phase = PH_LINE_START;
            res.ev       = EV_FIELD;
          end else begin
            st_nxt.phase = PH_DONE;
            res.ev       = EV_HEAD;
          end
        end else begin
          st_nxt.err   = ERR_CRLF;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end
      end
      PH_LINE_START, PH_NAME: begin
        st_nxt.field_len = len_base;
        if (data_byte == CH_CR && cur.phase == PH_LINE_START) begin
          st_nxt.phase = PH_END_LF;
        end else if (data_byte == CH_COLON) begin
          st_nxt.phase = PH_VALUE_WS;
        end else if (is_ws || len_over) begin
          st_nxt.err   = ERR_NAME;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end else begin
          st_nxt.field_len = len_inc;
          st_nxt.phase     = PH_NAME;
          res.ev           = EV_NAME;
          res.data         = lower;
        end
      end
      PH_VALUE_WS, PH_VALUE: begin
        st_nxt.field_len = len_base;
        if (data_byte == CH_CR) begin
          st_nxt.phase = PH_FIELD_LF;
        end else if (cur.phase == PH_VALUE_WS &&
                     (data_byte == CH_SPACE || data_byte == CH_TAB)) begin
          // drop optional whitespace ahead of the value
          st_nxt.phase = PH_VALUE_WS;
        end else if (len_over) begin
          st_nxt.err   = ERR_VALUE;
          st_nxt.phase = PH_ERROR;
          res.ev       = EV_ERROR;
        end else begin
          st_nxt.field_len = len_inc;
          st_nxt.phase     = PH_VALUE;
          res.ev           = EV_VALUE;
          res.data         = data_byte;
        end
      end
      PH_DONE: begin
        st_nxt.phase = PH_DONE;
      end
      default: begin
        st_nxt.phase = PH_ERROR;
        res.ev       = EV_ERROR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/hrhp_board_pkg.sv
// Scoreboard for the request head parser: per-byte predictor and result check.
`timescale 1ns / 1ps

package hrhp_board_pkg;
  import hrhp_pkg::*;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
    logic [1:0] meth;
    logic [3:0] major;
    logic [3:0] minor;
    logic [2:0] err;
  } head_word_t;

  class head_scoreboard;
    path_lim_t  path_lim;
    field_lim_t name_lim;
    field_lim_t value_lim;
    phase_t     phase;
    logic [2:0] verb_ok;
    len_cnt_t   flen;
    meth_code_t meth;
    logic [3:0] major;
    logic [3:0] minor;
    err_code_t  err;
    head_word_t due_q[$];
    int         n_bad;

    function new();
      path_lim  = LIM_RESET.path_lim;
      name_lim  = LIM_RESET.name_lim;
      value_lim = LIM_RESET.value_lim;
      n_bad     = 0;
      restart();
    endfunction

    function void restart();
      phase   = PH_LEADING;
      verb_ok = 3'b111;
      flen    = '0;
      meth    = METH_GET;
      major   = 4'd0;
      minor   = 4'd0;
      err     = ERR_NONE;
    endfunction

    function void set_limit(logic [1:0] idx, logic [12:0] val);
      case (idx)
        CFG_PATH_LEN:  path_lim = val;
        CFG_NAME_LEN:  name_lim = val[7:0];
        CFG_VALUE_LEN: value_lim = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function string verb_text(int k);
      case (k)
        0: return "GET";
        1: return "HEAD";
        default: return "POST";
      endcase
    endfunction

    function bit is_ws(logic [7:0] b);
      return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Drop every method candidate that no longer matches this byte.
    function void take_verb_byte(logic [7:0] b);
      string s;
      for (int k = 0; k < 3; k++) begin
        s = verb_text(k);
        if (flen >= s.len() || s[flen] != b) verb_ok[k] = 1'b0;
      end
      flen++;
    endfunction

    // Count one byte of a field; true once the limit is already reached.
    function bit over_limit(logic [12:0] lim);
      if (flen >= lim) return 1'b1;
      if (flen != '1) flen++;
      return 1'b0;
    endfunction

    function ev_code_t trip(err_code_t kind);
      err   = kind;
      phase = PH_ERROR;
      return EV_ERROR;
    endfunction

    function ev_code_t want_byte(logic [7:0] b, logic [7:0] ch, phase_t nxt, err_code_t kind);
      if (b != ch) return trip(kind);
      phase = nxt;
      return EV_CONSUMED;
    endfunction

    function void note_input(logic [7:0] b, logic bg);
      ev_code_t   ev;
      logic [7:0] ob;
      string      s;
      head_word_t w;
      ev = EV_CONSUMED;
      ob = 8'h00;
      if (bg) restart();
      case (phase)
        PH_LEADING: begin
          if (!is_ws(b)) begin
            verb_ok = 3'b111;
            flen    = '0;
            take_verb_byte(b);
            phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (b == CH_SPACE) begin
            ev = trip(ERR_METHOD);
            for (int k = 0; k < 3; k++) begin
              s = verb_text(k);
              if (verb_ok[k] && flen == s.len()) begin
                meth  = meth_code_t'(k);
                err   = ERR_NONE;
                phase = PH_SLASH;
                ev    = EV_CONSUMED;
              end
            end
          end else if (flen >= METHOD_MAX_LEN) begin
            ev = trip(ERR_METHOD);
          end else begin
            take_verb_byte(b);
          end
        end
        PH_SLASH: begin
          ev   = want_byte(b, CH_SLASH, PH_PATH, ERR_PATH);
          flen = '0;
        end
        PH_PATH: begin
          if (b == CH_SPACE) begin
            phase = PH_V_H;
          end else if (over_limit(path_lim)) begin
            ev = trip(ERR_PATH);
          end else begin
            ev = EV_PATH;
            ob = b;
          end
        end
        PH_V_H:     ev = want_byte(b, "H", PH_V_T1, ERR_VERSION);
        PH_V_T1:    ev = want_byte(b, "T", PH_V_T2, ERR_VERSION);
        PH_V_T2:    ev = want_byte(b, "T", PH_V_P, ERR_VERSION);
        PH_V_P:     ev = want_byte(b, "P", PH_V_SLASH, ERR_VERSION);
        PH_V_SLASH: ev = want_byte(b, CH_SLASH, PH_V_MAJOR, ERR_VERSION);
        PH_V_MAJOR: begin
          if (b < "0" || b > "9") begin
            ev = trip(ERR_VERSION);
          end else begin
            major = b[3:0];
            phase = PH_V_DOT;
          end
        end
        PH_V_DOT:   ev = want_byte(b, CH_DOT, PH_V_MINOR, ERR_VERSION);
        PH_V_MINOR: begin
          if (b < "0" || b > "9") begin
            ev = trip(ERR_VERSION);
          end else begin
            minor = b[3:0];
            phase = PH_RL_CR;
          end
        end
        PH_RL_CR:   ev = want_byte(b, CH_CR, PH_RL_LF, ERR_CRLF);
        PH_RL_LF: begin
          ev = want_byte(b, CH_LF, PH_LINE_START, ERR_CRLF);
          if (ev == EV_CONSUMED) ev = EV_LINE;
        end
        PH_LINE_START, PH_NAME: begin
          if (phase == PH_LINE_START) flen = '0;
          if (b == CH_CR && phase == PH_LINE_START) begin
            phase = PH_END_LF;
          end else if (b == CH_COLON) begin
            phase = PH_VALUE_WS;
          end else if (is_ws(b) || over_limit(13'(name_lim))) begin
            ev = trip(ERR_NAME);
          end else begin
            phase = PH_NAME;
            ev    = EV_NAME;
            ob    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          end
        end
        PH_VALUE_WS, PH_VALUE: begin
          if (phase == PH_VALUE_WS) flen = '0;
          if (b == CH_CR) begin
            phase = PH_FIELD_LF;
          end else if (phase == PH_VALUE_WS && (b == CH_SPACE || b == CH_TAB)) begin
            // skip whitespace ahead of the value
          end else if (over_limit(13'(value_lim))) begin
            ev = trip(ERR_VALUE);
          end else begin
            phase = PH_VALUE;
            ev    = EV_VALUE;
            ob    = b;
          end
        end
        PH_FIELD_LF: begin
          ev = want_byte(b, CH_LF, PH_LINE_START, ERR_CRLF);
          if (ev == EV_CONSUMED) ev = EV_FIELD;
        end
        PH_END_LF: begin
          ev = want_byte(b, CH_LF, PH_DONE, ERR_CRLF);
          if (ev == EV_CONSUMED) ev = EV_HEAD;
        end
        PH_DONE: ;
        default: begin
          phase = PH_ERROR;
          ev    = EV_ERROR;
        end
      endcase
      w.ev    = ev;
      w.data  = ob;
      w.meth  = meth;
      w.major = major;
      w.minor = minor;
      w.err   = err;
      due_q.push_back(w);
    endfunction

    function void check_result(logic [2:0] ev, logic [7:0] data, logic [1:0] meth_got,
                               logic [3:0] major_got, logic [3:0] minor_got,
                               logic [2:0] err_got);
      head_word_t want;
      if (due_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word: ev=%0d byte=%02h", ev, data);
        return;
      end
      want = due_q.pop_front();
      if (ev !== want.ev || data !== want.data || meth_got !== want.meth ||
          major_got !== want.major || minor_got !== want.minor || err_got !== want.err) begin
        n_bad++;
        if (n_bad <= 10)
          $display("word mismatch: expected ev=%0d byte=%02h meth=%0d ver=%0d.%0d err=%0d, got ev=%0d byte=%02h meth=%0d ver=%0d.%0d err=%0d",
                   want.ev, want.data, want.meth, want.major, want.minor, want.err,
                   ev, data, meth_got, major_got, minor_got, err_got);
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the request head parser: stimulus, stall pattern and final verdict.
`timescale 1ns / 1ps

module tb_top;
  import hrhp_pkg::*;
  import hrhp_board_pkg::*;

  localparam int HALF_NS       = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 90;
  localparam int N_PHASES      = 8;
  localparam int TIMEOUT_NS    = 20_000_000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_begin_request = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_out_byte;
  logic [1:0]  out_method_code;
  logic [3:0]  out_version_major;
  logic [3:0]  out_version_minor;
  logic [2:0]  out_error_kind;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [12:0] cfg_data = 13'd0;

  head_scoreboard board;
  logic [7:0]     req_q[$];
  bit             quiet = 1'b0;
  int             hold_left = 0;
  int             stall_dice;

  http_request_head_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_begin_request  (in_begin_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_out_byte      (out_out_byte),
    .out_method_code   (out_method_code),
    .out_version_major (out_version_major),
    .out_version_minor (out_version_minor),
    .out_error_kind    (out_error_kind),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #HALF_NS clk = ~clk;

  // Check the word taken at this edge, then pick the stall for the next cycles.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_event_res, out_out_byte, out_method_code,
                         out_version_major, out_version_minor, out_error_kind);
    if (quiet) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      stall_dice = $urandom_range(0, 99);
      out_stall <= (stall_dice >= 60);
      hold_left = (stall_dice >= 96) ? $urandom_range(12, 48) : $urandom_range(0, 3);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_but(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom); while (c == x);
    return c;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 1))
      return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    do c = 8'($urandom); while (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D) || c == CH_COLON);
    return c;
  endfunction

  function automatic logic [12:0] rand_limit(int small_max, int full_max);
    if ($urandom_range(0, 9) < 8) return 13'($urandom_range(0, small_max));
    return 13'($urandom_range(0, full_max));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic bg);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_begin_request <= bg;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_input(b, bg);
    gap = 0;
    if (!quiet) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 62) ? 0 : (gap < 92) ? $urandom_range(1, 3) :
            (gap < 98) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_begin_request <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_seq(input bit first_begin);
    foreach (req_q[i]) push_byte(req_q[i], first_begin && i == 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.set_limit(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected word is back, then let the pipe drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_head();
    int n;
    req_q.delete();
    repeat ($urandom_range(0, 2))
      req_q.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'(8'h09 + $urandom_range(0, 4)));
    case ($urandom_range(0, 2))
      0: add_text("GET");
      1: add_text("HEAD");
      default: add_text("POST");
    endcase
    add_text(" /");
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
    repeat (n) req_q.push_back(any_but(CH_SPACE));
    add_text(" HTTP/");
    req_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    add_text(".");
    req_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    add_text("\r\n");
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 8)) req_q.push_back(name_char());
      add_text(":");
      repeat ($urandom_range(0, 2)) req_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      repeat ($urandom_range(0, 10)) req_q.push_back(any_but(CH_CR));
      add_text("\r\n");
    end
    add_text("\r\n");
    // trailing bytes after the head
    repeat ($urandom_range(0, 2)) req_q.push_back(8'($urandom));
  endtask

  initial begin
    string probes[5] = '{"GETX ", "GETTING/", "POST x", "GET / HTTP/9.9\r\n\tx",
                         "GET / HTTP/0.0\r\nA:b\rX"};
    int sent;
    int dice;
    int pos;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Leading whitespace, path extremes, value with tab, empty name, bytes after the head.
    req_q.delete();
    req_q.push_back(CH_SPACE);
    req_q.push_back(CH_TAB);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
    add_text("HEAD /");
    req_q.push_back(8'h00);
    req_q.push_back(8'hFF);
    add_text(" HTTP/1.0\r\nX-Y:  v\tw\r\n:\r\n\r\nz");
    send_seq(1'b1);
    // Bad method, overlong method, missing slash, whitespace name start, stray CR.
    foreach (probes[i]) begin
      req_q.delete();
      add_text(probes[i]);
      send_seq(1'b1);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_PATH_LEN, 13'd8191);
          write_reg(CFG_NAME_LEN, 13'd255);
          write_reg(CFG_VALUE_LEN, 13'd255);
        end
        1: begin
          write_reg(CFG_PATH_LEN, 13'd1);
          write_reg(CFG_NAME_LEN, 13'd1);
          write_reg(CFG_VALUE_LEN, 13'd1);
        end
        2: begin
          write_reg(CFG_PATH_LEN, 13'd0);
          write_reg(CFG_NAME_LEN, 13'd0);
          write_reg(CFG_VALUE_LEN, 13'd0);
          write_reg(CFG_UNUSED, 13'h1FFF);
        end
        3: begin
          write_reg(CFG_PATH_LEN, 13'd3);
          write_reg(CFG_NAME_LEN, 13'h1F04);
          write_reg(CFG_VALUE_LEN, 13'h0A05);
        end
        default: begin
          write_reg(CFG_PATH_LEN, rand_limit(16, 8191));
          write_reg(CFG_NAME_LEN, {5'($urandom), 8'(rand_limit(12, 255))});
          write_reg(CFG_VALUE_LEN, {5'($urandom), 8'(rand_limit(14, 255))});
        end
      endcase
      quiet = (ph == 1 || ph == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        dice = $urandom_range(0, 99);
        if (dice < 10) begin
          repeat ($urandom_range(1, 8)) begin
            push_byte(8'($urandom), $urandom_range(0, 5) == 0);
            sent++;
          end
        end else begin
          build_head();
          // break some heads: overwrite, drop or insert one byte
          if (dice < 28) begin
            pos = $urandom_range(0, req_q.size() - 1);
            case ($urandom_range(0, 2))
              0: req_q[pos] = 8'($urandom);
              1: req_q.delete(pos);
              default: req_q.insert(pos, 8'($urandom));
            endcase
          end
          send_seq($urandom_range(0, 19) != 0);
          sent += req_q.size();
        end
      end
    end

    settle();
    if (board.n_bad == 0 && board.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
